/* rtl/mdhp_pkg.sv */
// Shared types, token tables and event codes for the modem data header parser.
`timescale 1ns / 1ps

package mdhp_pkg;

    // Result event codes
    typedef enum logic [1:0] {
        EV_READY     = 2'd0,
        EV_HEADER    = 2'd1,
        EV_MALFORMED = 2'd2,
        EV_TIMEOUT   = 2'd3
    } event_t;

    // Parse phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ID   = 2'd1,
        PH_LEN  = 2'd2
    } phase_t;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Token lengths
    localparam logic [2:0] READY_LEN = 3'd7;
    localparam logic [2:0] TAG_LEN   = 3'd5;

    // Field separators and digit bounds
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Window register reset value
    localparam logic [15:0] WINDOW_RESET = 16'd100;

    // Saturation limit of the tick counter
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // "ready\r\n" token, one character per index
    function automatic logic [7:0] ready_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h61;
            3'd3:    ch = 8'h64;
            3'd4:    ch = 8'h79;
            3'd5:    ch = 8'h0D;
            3'd6:    ch = 8'h0A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "+IPD," token, one character per index
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h49;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h44;
            3'd4:    ch = 8'h2C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/modem_data_header_parser.sv */
// Modem data header parser: token hunt, id/length digit parsing and tick timeout.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    operation, rx_byte
// output    out_valid / out_ready  event_res, link_id, length
// config    cfg_we                 cfg_data (window_ticks)
//
// One beat per cycle sustained: an input register feeds one pass of match,
// accumulate and tick logic, which writes the parser state and the result
// register in the same cycle. A beat with no result always moves on; a beat
// with a result waits only while the result register is held by out_ready.
// Reset (rst_n low) clears all parse state and sets the window to 100 ticks.
module modem_data_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic [7:0]  link_id,
    output logic [15:0] length,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    // Config register
    logic [15:0] window_reg;

    // Input register
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [7:0]  s1_byte_reg;

    // Parser state
    mdhp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  ready_idx_reg, ready_idx_next;
    logic [2:0]  tag_idx_reg, tag_idx_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] tick_reg, tick_next;

    // Result register
    logic              out_valid_reg;
    mdhp_pkg::event_t  out_event_reg;
    logic [7:0]        out_id_reg;
    logic [15:0]       out_len_reg;

    // Result of the current pass
    logic              res_valid;
    mdhp_pkg::event_t  res_event;
    logic [7:0]        res_id;
    logic [15:0]       res_len;

    // Helpers
    logic        s1_adv;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [11:0] id_wide;
    logic [19:0] len_wide;
    logic [15:0] tick_inc;
    logic        ready_hit;
    logic        tag_hit;
    logic [2:0]  ready_idx_inc;
    logic [2:0]  tag_idx_inc;
    logic        clear_all;

    // Handshake
    assign s1_adv   = s1_valid_reg && (!res_valid || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // Digit decode and accumulator arithmetic
    assign is_digit  = (s1_byte_reg >= mdhp_pkg::CH_ZERO) && (s1_byte_reg <= mdhp_pkg::CH_NINE);
    assign digit_val = is_digit ? 4'(s1_byte_reg - mdhp_pkg::CH_ZERO) : 4'd0;
    assign id_wide   = 12'(id_reg) * 12'd10 + 12'(digit_val);
    assign len_wide  = 20'(len_reg) * 20'd10 + 20'(digit_val);
    assign tick_inc  = (tick_reg == mdhp_pkg::TICK_MAX) ? tick_reg : tick_reg + 16'd1;

    // Token matching
    assign ready_hit     = (ready_idx_reg < mdhp_pkg::READY_LEN)
                           && (s1_byte_reg == mdhp_pkg::ready_char(ready_idx_reg));
    assign tag_hit       = (tag_idx_reg < mdhp_pkg::TAG_LEN)
                           && (s1_byte_reg == mdhp_pkg::tag_char(tag_idx_reg));
    assign ready_idx_inc = ready_idx_reg + 3'd1;
    assign tag_idx_inc   = tag_idx_reg + 3'd1;

    // One parse pass over the registered beat
    always_comb
    begin
        phase_next     = phase_reg;
        ready_idx_next = ready_idx_reg;
        tag_idx_next   = tag_idx_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        tick_next      = tick_reg;
        res_valid      = 1'b0;
        res_event      = mdhp_pkg::EV_READY;
        res_id         = 8'd0;
        res_len        = 16'd0;
        clear_all      = 1'b0;

        if (s1_op_reg == mdhp_pkg::OP_TICK)
        begin
            tick_next = tick_inc;
            if (tick_inc >= window_reg)
            begin
                res_valid = 1'b1;
                res_event = mdhp_pkg::EV_TIMEOUT;
                clear_all = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                mdhp_pkg::PH_ID:
                begin
                    if (s1_byte_reg == mdhp_pkg::CH_COMMA)
                    begin
                        phase_next = mdhp_pkg::PH_LEN;
                    end
                    else if (!is_digit)
                    begin
                        res_valid = 1'b1;
                        res_event = mdhp_pkg::EV_MALFORMED;
                        clear_all = 1'b1;
                    end
                    else
                    begin
                        id_next = (id_wide > 12'd255) ? 8'd255 : id_wide[7:0];
                    end
                end
                mdhp_pkg::PH_LEN:
                begin
                    if (s1_byte_reg == mdhp_pkg::CH_COLON)
                    begin
                        res_valid = 1'b1;
                        res_event = mdhp_pkg::EV_HEADER;
                        res_id    = id_reg;
                        res_len   = len_reg;
                        clear_all = 1'b1;
                    end
                    else if (!is_digit)
                    begin
                        res_valid = 1'b1;
                        res_event = mdhp_pkg::EV_MALFORMED;
                        clear_all = 1'b1;
                    end
                    else
                    begin
                        len_next = (len_wide > 20'd65535) ? 16'hFFFF : len_wide[15:0];
                    end
                end
                default:
                begin
                    // hunt: both tokens tracked side by side
                    if (ready_hit && (ready_idx_inc == mdhp_pkg::READY_LEN))
                    begin
                        res_valid = 1'b1;
                        res_event = mdhp_pkg::EV_READY;
                        clear_all = 1'b1;
                    end
                    else
                    begin
                        if (ready_hit)
                            ready_idx_next = ready_idx_inc;
                        else
                            ready_idx_next = (s1_byte_reg == mdhp_pkg::ready_char(3'd0))
                                             ? 3'd1 : 3'd0;

                        if (tag_hit && (tag_idx_inc == mdhp_pkg::TAG_LEN))
                        begin
                            phase_next     = mdhp_pkg::PH_ID;
                            ready_idx_next = 3'd0;
                            tag_idx_next   = 3'd0;
                            id_next        = 8'd0;
                            len_next       = 16'd0;
                        end
                        else if (tag_hit)
                            tag_idx_next = tag_idx_inc;
                        else
                            tag_idx_next = (s1_byte_reg == mdhp_pkg::tag_char(3'd0))
                                           ? 3'd1 : 3'd0;
                    end
                end
            endcase
        end

        // every result restarts parsing
        if (clear_all)
        begin
            phase_next     = mdhp_pkg::PH_HUNT;
            ready_idx_next = 3'd0;
            tag_idx_next   = 3'd0;
            id_next        = 8'd0;
            len_next       = 16'd0;
            tick_next      = 16'd0;
        end
    end

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= mdhp_pkg::WINDOW_RESET;
        else if (cfg_we)
            window_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_op_reg   <= operation;
            s1_byte_reg <= rx_byte;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mdhp_pkg::PH_HUNT;
            ready_idx_reg <= 3'd0;
            tag_idx_reg   <= 3'd0;
            id_reg        <= 8'd0;
            len_reg       <= 16'd0;
            tick_reg      <= 16'd0;
        end
        else if (s1_adv)
        begin
            phase_reg     <= phase_next;
            ready_idx_reg <= ready_idx_next;
            tag_idx_reg   <= tag_idx_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            tick_reg      <= tick_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res_valid)
        begin
            out_event_reg <= res_event;
            out_id_reg    <= res_id;
            out_len_reg   <= res_len;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign link_id   = out_id_reg;
    assign length    = out_len_reg;

endmodule
